FILE: rtl/pshh_pkg.sv
package pshh_pkg;

	localparam int PC_W = 64;
	localparam int CNT_W = 32;
	localparam int TABLE_SLOTS_DEF = 8192;
	localparam int HASH_SHIFT_DEF = 2;

	typedef enum logic [1:0] {
		OUT_CLAIM  = 2'd0,
		OUT_INC    = 2'd1,
		OUT_DROP   = 2'd2,
		OUT_IGNORE = 2'd3
	} outcome_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic             empty;
		logic             match;
		logic [CNT_W-1:0] next_count;
	} probe_res_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
	endfunction

endpackage

FILE: rtl/pshh_table.sv
module pshh_table #(
	parameter int DEPTH = pshh_pkg::TABLE_SLOTS_DEF,
	parameter int DATA_W = pshh_pkg::PC_W + pshh_pkg::CNT_W
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/pshh_probe_unit.sv
module pshh_probe_unit (
	input  logic [pshh_pkg::PC_W-1:0]  entry_pc,
	input  logic [pshh_pkg::CNT_W-1:0] entry_count,
	input  logic [pshh_pkg::PC_W-1:0]  pc,
	output pshh_pkg::probe_res_t       res
);

	// A slot with a zero count is empty; its stored pc is meaningless.
	always_comb begin
		res.empty = (entry_count == '0);
		res.match = !res.empty && (entry_pc == pc);
		res.next_count = res.empty ? pshh_pkg::CNT_W'(1) : pshh_pkg::sat_inc(entry_count);
	end

endmodule

FILE: rtl/pc_sample_hash_histogram.sv
// Program-counter sample histogram in an open-addressed hash table.
// Input channel: in_valid/in_ready carries one sample_pc word. Output channel:
// out_valid/out_ready carries one result word per sample: the outcome code,
// the slot and its count, and snapshots of the total, used and dropped counters.
// Configuration: cfg_wen writes cfg_wdata into the sampling enable bit at once.
// Each enabled sample is probed from its home slot, one table slot per cycle,
// through a single read port of the table and one compare/increment unit.
// A sample resolves at the first probe that finds an empty or matching slot;
// if every slot has been probed without one, the sample is dropped.
// A disabled sample is not probed; it still produces an IGNORE result word.
// One sample is processed at a time; in_ready is high only while idle.
// After reset a clearing pass writes every slot empty, one slot per cycle,
// and in_ready stays low until the pass ends.
// The output register holds a finished result while the receiver stalls; the
// next sample is still accepted and its result waits in a holding register.
module pc_sample_hash_histogram #(
	parameter int TABLE_SLOTS = pshh_pkg::TABLE_SLOTS_DEF,
	parameter int HASH_SHIFT = pshh_pkg::HASH_SHIFT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic                              cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [pshh_pkg::PC_W-1:0]         sample_pc,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        outcome,
	output logic [$clog2(TABLE_SLOTS)-1:0]    slot_index,
	output logic [pshh_pkg::CNT_W-1:0]        slot_count,
	output logic [pshh_pkg::CNT_W-1:0]        total_samples,
	output logic [$clog2(TABLE_SLOTS):0]      used_slots,
	output logic [pshh_pkg::CNT_W-1:0]        dropped_samples
);

	localparam int SLOT_W = $clog2(TABLE_SLOTS);
	localparam int PC_W = pshh_pkg::PC_W;
	localparam int CNT_W = pshh_pkg::CNT_W;
	localparam int ENTRY_W = PC_W + CNT_W;

	pshh_pkg::state_t state_q, state_d;

	logic              en_q;
	logic [SLOT_W-1:0] clr_q;
	logic [CNT_W-1:0]  total_q;
	logic [SLOT_W:0]   used_q;
	logic [CNT_W-1:0]  drop_q;
	logic              out_valid_q;

	logic [PC_W-1:0]   pc_q;
	logic [SLOT_W-1:0] idx_q;
	logic [SLOT_W-1:0] probe_q;

	pshh_pkg::outcome_t out_outcome_q, hold_outcome_q, res_outcome;
	logic [SLOT_W-1:0]  out_slot_q, hold_slot_q, res_slot;
	logic [CNT_W-1:0]   out_count_q, hold_count_q, res_count;
	logic [CNT_W-1:0]   out_total_q, hold_total_q, res_total;
	logic [SLOT_W:0]    out_used_q, hold_used_q, res_used;
	logic [CNT_W-1:0]   out_drop_q, hold_drop_q, res_drop;

	logic              in_acc, out_free, hit, last, resolve, load_out, load_hold;
	logic [PC_W-1:0]   pc_shifted;
	logic [SLOT_W-1:0] home;
	logic [SLOT_W-1:0] idx_next;

	logic               mem_we;
	logic [SLOT_W-1:0]  mem_waddr, mem_raddr;
	logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

	pshh_pkg::probe_res_t pr;

	assign pc_shifted = sample_pc >> HASH_SHIFT;
	assign home = pc_shifted[SLOT_W-1:0];
	assign idx_next = idx_q + SLOT_W'(1);

	assign in_ready = (state_q == pshh_pkg::ST_IDLE);
	assign in_acc = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	pshh_table #(
		.DEPTH(TABLE_SLOTS),
		.DATA_W(ENTRY_W)
	) u_table (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	pshh_probe_unit u_probe (
		.entry_pc(mem_rdata[ENTRY_W-1:CNT_W]),
		.entry_count(mem_rdata[CNT_W-1:0]),
		.pc(pc_q),
		.res(pr)
	);

	assign hit = pr.empty || pr.match;
	assign last = (probe_q == {SLOT_W{1'b1}});

	// The read port always fetches the slot that the next cycle will examine.
	always_comb begin
		mem_raddr = (state_q == pshh_pkg::ST_CHECK) ? idx_next : home;
		mem_we = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = {pc_q, pr.next_count};
		if (state_q == pshh_pkg::ST_CLEAR) begin
			mem_we = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (state_q == pshh_pkg::ST_CHECK && hit) begin
			mem_we = 1'b1;
		end
	end

	always_comb begin
		res_outcome = pshh_pkg::OUT_IGNORE;
		res_slot = '0;
		res_count = '0;
		res_total = total_q;
		res_used = used_q;
		res_drop = drop_q;
		resolve = in_acc && !en_q;
		if (state_q == pshh_pkg::ST_CHECK) begin
			resolve = hit || last;
			if (pr.empty) begin
				res_outcome = pshh_pkg::OUT_CLAIM;
				res_used = used_q + (SLOT_W+1)'(1);
			end else if (pr.match) begin
				res_outcome = pshh_pkg::OUT_INC;
			end else begin
				res_outcome = pshh_pkg::OUT_DROP;
				if (last) begin
					res_drop = pshh_pkg::sat_inc(drop_q);
				end
			end
			if (hit) begin
				res_slot = idx_q;
				res_count = pr.next_count;
			end
		end
		load_out = (resolve && out_free) || (state_q == pshh_pkg::ST_HOLD && out_free);
		load_hold = resolve && !out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pshh_pkg::ST_CLEAR: begin
				if (clr_q == {SLOT_W{1'b1}}) begin
					state_d = pshh_pkg::ST_IDLE;
				end
			end
			pshh_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (en_q) begin
						state_d = pshh_pkg::ST_CHECK;
					end else if (!out_free) begin
						state_d = pshh_pkg::ST_HOLD;
					end
				end
			end
			pshh_pkg::ST_CHECK: begin
				if (resolve) begin
					state_d = out_free ? pshh_pkg::ST_IDLE : pshh_pkg::ST_HOLD;
				end
			end
			pshh_pkg::ST_HOLD: begin
				if (out_free) begin
					state_d = pshh_pkg::ST_IDLE;
				end
			end
			default: state_d = pshh_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pshh_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b1;
			clr_q <= '0;
			total_q <= '0;
			used_q <= '0;
			drop_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				en_q <= cfg_wdata;
			end
			if (state_q == pshh_pkg::ST_CLEAR) begin
				clr_q <= clr_q + SLOT_W'(1);
			end
			if (in_acc && en_q) begin
				total_q <= pshh_pkg::sat_inc(total_q);
			end
			if (state_q == pshh_pkg::ST_CHECK && resolve) begin
				used_q <= res_used;
				drop_q <= res_drop;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pc_q <= sample_pc;
			idx_q <= home;
			probe_q <= '0;
		end else if (state_q == pshh_pkg::ST_CHECK && !hit) begin
			idx_q <= idx_next;
			probe_q <= probe_q + SLOT_W'(1);
		end
		if (load_hold) begin
			hold_outcome_q <= res_outcome;
			hold_slot_q <= res_slot;
			hold_count_q <= res_count;
			hold_total_q <= res_total;
			hold_used_q <= res_used;
			hold_drop_q <= res_drop;
		end
		if (load_out) begin
			if (state_q == pshh_pkg::ST_HOLD) begin
				out_outcome_q <= hold_outcome_q;
				out_slot_q <= hold_slot_q;
				out_count_q <= hold_count_q;
				out_total_q <= hold_total_q;
				out_used_q <= hold_used_q;
				out_drop_q <= hold_drop_q;
			end else begin
				out_outcome_q <= res_outcome;
				out_slot_q <= res_slot;
				out_count_q <= res_count;
				out_total_q <= res_total;
				out_used_q <= res_used;
				out_drop_q <= res_drop;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign outcome = out_outcome_q;
	assign slot_index = out_slot_q;
	assign slot_count = out_count_q;
	assign total_samples = out_total_q;
	assign used_slots = out_used_q;
	assign dropped_samples = out_drop_q;

endmodule

FILE: rtl/pshh_checker.sv
module pshh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  outcome,
	input logic [31:0] slot_count,
	input logic [31:0] total_samples,
	input logic [31:0] dropped_samples
);

	// A stalled result word must stay valid, and its outcome, slot count and total must not change.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(slot_count)
			&& $stable(total_samples))
		else $error("output word changed while stalled");

	a_claim_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outcome == pshh_pkg::OUT_CLAIM |-> slot_count == 32'd1)
		else $error("claimed slot does not report a count of one");

	a_inc_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outcome == pshh_pkg::OUT_INC |-> slot_count != 32'd0 && slot_count != 32'd1)
		else $error("incremented slot reports a count below two");

	a_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome == pshh_pkg::OUT_DROP || outcome == pshh_pkg::OUT_IGNORE)
			|-> slot_count == 32'd0 && dropped_samples <= total_samples)
		else $error("dropped or ignored word reports a slot count or bad counters");

endmodule

bind pc_sample_hash_histogram pshh_checker u_pshh_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.outcome(outcome),
	.slot_count(slot_count),
	.total_samples(total_samples),
	.dropped_samples(dropped_samples)
);
